>>> src/dpb_pkg.sv
// package: widths, register indexes and reset values for depth pixel back-projection
`default_nettype none

package dpb_pkg;

    // input field widths
    localparam int DEPTH_BITS = 16;
    localparam int COORD_BITS = 12;

    // register file
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int INV_W      = 24;
    localparam int CENTER_W   = 16;
    localparam int OUT_W      = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_DEPTH_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y        = 3'd4;

    localparam logic [INV_W-1:0]    RST_INV_DEPTH_SCALE = 24'd16777;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL       = 24'd31957;
    localparam logic [CENTER_W-1:0] RST_CENTER_X        = 16'd5112;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 16'd3832;

    // datapath widths
    localparam int DPROD_W = DEPTH_BITS + INV_W;             // depth * scale, Q.24
    localparam int ZEXT_W  = 48;                             // z widened for compares
    localparam int ZXY_W   = 32;                             // z used for x and y
    localparam int MAG_W   = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
    localparam int PROD_W  = MAG_W + ZXY_W;                  // |dx| * z, Q.20
    localparam int HALF_W  = INV_W / 2;                      // split of the reciprocal
    localparam int A_W     = PROD_W + HALF_W;
    localparam int B_W     = PROD_W + HALF_W + 1;
    localparam int R_W     = B_W - 16;

    localparam int unsigned POS_MAX = 8388607;
    localparam int unsigned NEG_MAX = 8388608;

endpackage : dpb_pkg

`default_nettype wire

>>> src/dpb_if.sv
// interfaces: pixel input, point output and register write channels
`default_nettype none

interface dpb_pix_if;
    import dpb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DEPTH_BITS-1:0] depth_value;
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;

    modport source (output valid, output depth_value, output pixel_col, output pixel_row,
                    input ready);
    modport sink   (input valid, input depth_value, input pixel_col, input pixel_row,
                    output ready);
endinterface : dpb_pix_if

interface dpb_point_if;
    import dpb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic        [OUT_W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                     output ready);
endinterface : dpb_point_if

interface dpb_cfg_if;
    import dpb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface : dpb_cfg_if

`default_nettype wire

>>> src/depth_pixel_backprojection.sv
// top level: pinhole back-projection of depth pixels into Q8.16 points
//
// usage
//   pix   : input items (depth_value, pixel_col, pixel_row), valid/ready
//   point : result items (point_x, point_y, point_z), valid/ready
//   cfg   : register writes (index, wdata), always ready, to be sent only while
//           idle; the block itself leaves that unenforced
// a depth of zero is accepted and dropped: it makes no result item
// stages: s1 depth*scale multiply and lateral offsets, s2 z rounding and clamps,
//   s3 |offset|*z, s4 product * reciprocal split in two 12-bit halves,
//   s5 half recombine and rounding, s6 saturation and sign (output register)
// throughput: one item per cycle while point is ready; each stage holds one item
// with its valid bit, so the six-deep pipeline streams at full rate
// stall: a stage moves forward only when the one after it is empty or
//   moving, so a held point back-pressures to pix.ready without losing or
//   repeating items; pix.ready stays high while there are empty stages
// reset: pipeline valids clear, registers return to their default camera
`default_nettype none

module depth_pixel_backprojection (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dpb_pix_if.sink       pix,
    dpb_point_if.source   point,
    dpb_cfg_if.sink       cfg
);
    import dpb_pkg::*;

    // ------------------------------------------------------------ registers
    logic [INV_W-1:0]    inv_depth_scale_reg;
    logic [INV_W-1:0]    inv_focal_x_reg;
    logic [INV_W-1:0]    inv_focal_y_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_depth_scale_reg <= RST_INV_DEPTH_SCALE;
            inv_focal_x_reg     <= RST_INV_FOCAL;
            inv_focal_y_reg     <= RST_INV_FOCAL;
            center_x_reg        <= RST_CENTER_X;
            center_y_reg        <= RST_CENTER_Y;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_INV_DEPTH_SCALE: inv_depth_scale_reg <= cfg.wdata[INV_W-1:0];
                CFG_INV_FOCAL_X:     inv_focal_x_reg     <= cfg.wdata[INV_W-1:0];
                CFG_INV_FOCAL_Y:     inv_focal_y_reg     <= cfg.wdata[INV_W-1:0];
                CFG_CENTER_X:        center_x_reg        <= cfg.wdata[CENTER_W-1:0];
                CFG_CENTER_Y:        center_y_reg        <= cfg.wdata[CENTER_W-1:0];
                default:             ; // writes beyond the register list are dropped
            endcase
        end
    end

    // lane 0 is x, lane 1 is y
    logic [INV_W-1:0]    inv_lane   [2];
    logic [CENTER_W-1:0] center_lane[2];
    logic [COORD_BITS-1:0] coord_lane [2];

    assign inv_lane[0]    = inv_focal_x_reg;
    assign inv_lane[1]    = inv_focal_y_reg;
    assign center_lane[0] = center_x_reg;
    assign center_lane[1] = center_y_reg;
    assign coord_lane[0]  = pix.pixel_col;
    assign coord_lane[1]  = pix.pixel_row;

    // ------------------------------------------------------------ pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // a stage loads when it is empty or its item moves on
    assign en6 = !v6_reg || point.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pix.ready = en1;

    logic pix_take;
    logic v1_next;

    assign pix_take = pix.valid && pix.ready;
    // zero depth means no measurement: item is consumed here
    assign v1_next  = pix.valid && (pix.depth_value != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= v1_next;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------ s1
    // depth product and signed lateral offsets in Q.4
    logic [DPROD_W-1:0] dprod1_next;
    logic [MAG_W-1:0]   mag1_next [2];
    logic               neg1_next [2];
    logic [DPROD_W-1:0] dprod1_reg;
    logic [MAG_W-1:0]   mag1_reg  [2];
    logic               neg1_reg  [2];

    always_comb
    begin
        logic [MAG_W-1:0] c16;
        logic [MAG_W-1:0] cen;
        dprod1_next = DPROD_W'(pix.depth_value) * DPROD_W'(inv_depth_scale_reg);
        for (int l = 0; l < 2; l++)
        begin
            c16          = MAG_W'(coord_lane[l]) << 4;
            cen          = MAG_W'(center_lane[l]);
            neg1_next[l] = c16 < cen;
            mag1_next[l] = neg1_next[l] ? (cen - c16) : (c16 - cen);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dprod1_reg <= dprod1_next;
            for (int l = 0; l < 2; l++)
            begin
                mag1_reg[l] <= mag1_next[l];
                neg1_reg[l] <= neg1_next[l];
            end
        end
    end

    // ------------------------------------------------------------ s2
    // z rounded to Q.16, clamped copy for x/y, saturated point_z
    logic [ZEXT_W-1:0] z_ext;
    logic [ZXY_W-1:0]  zxy2_next;
    logic [OUT_W-1:0]  pz2_next;
    logic [ZXY_W-1:0]  zxy2_reg;
    logic [OUT_W-1:0]  pz2_reg;
    logic [MAG_W-1:0]  mag2_reg [2];
    logic              neg2_reg [2];

    always_comb
    begin
        logic [DPROD_W:0] zsum;
        zsum      = (DPROD_W+1)'(dprod1_reg) + ((DPROD_W+1)'(1) << 7);
        z_ext     = ZEXT_W'(zsum >> 8);
        zxy2_next = (z_ext > ZEXT_W'({ZXY_W{1'b1}})) ? {ZXY_W{1'b1}} : z_ext[ZXY_W-1:0];
        pz2_next  = (z_ext > ZEXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : z_ext[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            zxy2_reg <= zxy2_next;
            pz2_reg  <= pz2_next;
            for (int l = 0; l < 2; l++)
            begin
                mag2_reg[l] <= mag1_reg[l];
                neg2_reg[l] <= neg1_reg[l];
            end
        end
    end

    // ------------------------------------------------------------ s3
    // |offset| * z, Q.20
    logic [PROD_W-1:0] prod3_reg [2];
    logic              neg3_reg  [2];
    logic [OUT_W-1:0]  pz3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            pz3_reg <= pz2_reg;
            for (int l = 0; l < 2; l++)
            begin
                prod3_reg[l] <= PROD_W'(mag2_reg[l]) * PROD_W'(zxy2_reg);
                neg3_reg[l]  <= neg2_reg[l];
            end
        end
    end

    // ------------------------------------------------------------ s4
    // product times the reciprocal as two half-width partial products,
    // rounding constant folded into the low half
    logic [A_W-1:0]   a4_reg  [2];
    logic [B_W-1:0]   b4_reg  [2];
    logic             neg4_reg[2];
    logic [OUT_W-1:0] pz4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            pz4_reg <= pz3_reg;
            for (int l = 0; l < 2; l++)
            begin
                a4_reg[l]   <= A_W'(prod3_reg[l]) * A_W'(inv_lane[l][INV_W-1:HALF_W]);
                b4_reg[l]   <= B_W'(prod3_reg[l]) * B_W'(inv_lane[l][HALF_W-1:0])
                               + (B_W'(1) << 27);
                neg4_reg[l] <= neg3_reg[l];
            end
        end
    end

    // ------------------------------------------------------------ s5
    // recombine halves: r = (prod*inv + 2^27) >> 28
    logic [R_W-1:0]   r5_reg  [2];
    logic             neg5_reg[2];
    logic [OUT_W-1:0] pz5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            pz5_reg <= pz4_reg;
            for (int l = 0; l < 2; l++)
            begin
                r5_reg[l]   <= R_W'((B_W'(a4_reg[l]) + (b4_reg[l] >> HALF_W)) >> 16);
                neg5_reg[l] <= neg4_reg[l];
            end
        end
    end

    // ------------------------------------------------------------ s6
    // saturate magnitude, apply sign, output register
    logic [OUT_W-1:0] coord6_next[2];
    logic [OUT_W-1:0] coord6_reg [2];
    logic [OUT_W-1:0] pz6_reg;

    always_comb
    begin
        logic [OUT_W-1:0] mag_sat;
        for (int l = 0; l < 2; l++)
        begin
            if (neg5_reg[l])
            begin
                mag_sat = (r5_reg[l] > R_W'(NEG_MAX)) ? OUT_W'(NEG_MAX)
                                                      : r5_reg[l][OUT_W-1:0];
                coord6_next[l] = OUT_W'(0) - mag_sat;
            end
            else
            begin
                mag_sat = (r5_reg[l] > R_W'(POS_MAX)) ? OUT_W'(POS_MAX)
                                                      : r5_reg[l][OUT_W-1:0];
                coord6_next[l] = mag_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            pz6_reg <= pz5_reg;
            for (int l = 0; l < 2; l++)
            begin
                coord6_reg[l] <= coord6_next[l];
            end
        end
    end

    assign point.valid   = v6_reg;
    assign point.point_x = coord6_reg[0];
    assign point.point_y = coord6_reg[1];
    assign point.point_z = pz6_reg;

    // ------------------------------------------------------------ checks
    // an accepted zero-depth item never enters the pipeline
    a_zero_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_take && pix.depth_value == '0) |=> !v1_reg)
        else $error("zero-depth item entered pipeline");

    // an accepted measurement always lands in the first stage
    a_meas_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_take && pix.depth_value != '0) |=> v1_reg)
        else $error("accepted depth item lost at entry");

    // an item waiting in stage 5 behind a stalled output is kept
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !en6) |=> v5_reg)
        else $error("stage 5 item dropped during stall");

endmodule : depth_pixel_backprojection

`default_nettype wire

>>> test/tb_depth_pixel_backprojection.sv
// testbench: depth pixel back-projection checked point by point against a fixed-point predictor
module tb_depth_pixel_backprojection;
    timeunit 1ns;
    timeprecision 1ps;

    import dpb_pkg::*;

    // pipeline depth from the block header, plus margin when waiting for it to empty
    localparam int PIPE_LATENCY    = 6;
    localparam int DRAIN_LIMIT     = 20000;
    // random part: camera settings and nonzero items per setting
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 96;
    // phase in which the point side holds off long enough to back the block up
    localparam int HOLD_PHASE      = 2;
    localparam int LONG_HOLD       = 300;

    // directed camera settings
    localparam int CAM_DEFAULT    = 0;
    localparam int CAM_FULL_SCALE = 1;
    localparam int CAM_ZERO_SCALE = 2;
    localparam int CAM_EXACT      = 3;
    localparam int DIR_CAMS       = 4;
    localparam int DIR_ROWS       = 24;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic        [OUT_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic [INV_W-1:0]    inv_depth;
        logic [INV_W-1:0]    inv_fx;
        logic [INV_W-1:0]    inv_fy;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
    } cam_cfg_t;

    // how a directed row gets its expected point
    typedef enum int {ROW_PREDICT, ROW_NONE, ROW_TYPED} row_kind_t;

    typedef struct {
        int                    cam;
        logic [DEPTH_BITS-1:0] depth;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        row_kind_t             kind;
        int                    want_x;
        int                    want_y;
        int                    want_z;
    } dir_row_t;

    logic clk;
    logic rst_n;

    dpb_pix_if   pix_ch ();
    dpb_point_if pt_ch ();
    dpb_cfg_if   cfg_ch ();

    depth_pixel_backprojection uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .point (pt_ch),
        .cfg   (cfg_ch)
    );

    // camera registers as the block should hold them, starting from the reset values
    logic [INV_W-1:0]    cam_inv_depth = RST_INV_DEPTH_SCALE;
    logic [INV_W-1:0]    cam_inv_fx    = RST_INV_FOCAL;
    logic [INV_W-1:0]    cam_inv_fy    = RST_INV_FOCAL;
    logic [CENTER_W-1:0] cam_cx        = RST_CENTER_X;
    logic [CENTER_W-1:0] cam_cy        = RST_CENTER_Y;

    // points still owed by the block, oldest first
    point_t pending_points [$];
    point_t oldest_point;

    // idling controls for the sender and the point side
    bit sender_idle_on = 1'b1;
    bit sink_idle_on   = 1'b1;
    bit hold_request   = 1'b0;

    int n_pixels       = 0;
    int n_dropped      = 0;
    int n_points       = 0;
    int n_mismatch     = 0;
    int n_cam_loads    = 0;
    int n_input_stalls = 0;

    cam_cfg_t dir_cams [DIR_CAMS] = '{
        '{RST_INV_DEPTH_SCALE, RST_INV_FOCAL, RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y},
        // every reciprocal at full scale, principal point in opposite corners
        '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h0000, 16'hFFFF},
        // zero depth scale: z is zero, so every point collapses to the origin
        '{24'h000000, 24'h000000, 24'h000000, 16'hFFFF, 16'h0000},
        // z = 4096 * depth exactly, x = (col - 100) * depth / 2 so ties land on .5,
        // y = (row - 50) * depth * 32
        '{24'h100000, 24'h000800, 24'h020000, 16'd1600, 16'd800}
    };

    dir_row_t dir_rows [DIR_ROWS] = '{
        // default camera: zero depth at both corners makes no point
        '{CAM_DEFAULT,    16'd0,     12'd0,     12'd0,     ROW_NONE,    0, 0, 0},
        '{CAM_DEFAULT,    16'd0,     12'd4095,  12'd4095,  ROW_NONE,    0, 0, 0},
        '{CAM_DEFAULT,    16'd1,     12'd0,     12'd0,     ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'd65535, 12'd4095,  12'd4095,  ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'd65535, 12'd0,     12'd0,     ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'd1000,  12'd320,   12'd240,   ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'd1000,  12'd319,   12'd239,   ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'd32768, 12'd2048,  12'd2048,  ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'hAAAA,  12'h555,   12'hAAA,   ROW_PREDICT, 0, 0, 0},
        '{CAM_DEFAULT,    16'h5555,  12'hAAA,   12'h555,   ROW_PREDICT, 0, 0, 0},
        // full scale: z and y pinned at their limits, x pinned in the first row and zero in the next
        '{CAM_FULL_SCALE, 16'd65535, 12'd4095,  12'd0,     ROW_TYPED,
          8388607, -8388608, 16777215},
        '{CAM_FULL_SCALE, 16'd65535, 12'd0,     12'd4095,  ROW_TYPED,
          0, -8388608, 16777215},
        '{CAM_FULL_SCALE, 16'd1,     12'd1,     12'd4095,  ROW_PREDICT, 0, 0, 0},
        '{CAM_FULL_SCALE, 16'd0,     12'd2048,  12'd2048,  ROW_NONE,    0, 0, 0},
        // nonzero depth with z rounding to zero still makes a point
        '{CAM_ZERO_SCALE, 16'd65535, 12'd4095,  12'd4095,  ROW_TYPED,   0, 0, 0},
        '{CAM_ZERO_SCALE, 16'd1,     12'd0,     12'd0,     ROW_TYPED,   0, 0, 0},
        // exact camera: on the axis, half steps either side, one and a half below
        '{CAM_EXACT,      16'd2,     12'd100,   12'd50,    ROW_TYPED,   0, 0, 8192},
        '{CAM_EXACT,      16'd1,     12'd101,   12'd49,    ROW_TYPED,   1, -32, 4096},
        '{CAM_EXACT,      16'd1,     12'd99,    12'd51,    ROW_TYPED,   -1, 32, 4096},
        '{CAM_EXACT,      16'd1,     12'd97,    12'd50,    ROW_TYPED,   -2, 0, 4096},
        '{CAM_EXACT,      16'd3,     12'd0,     12'd0,     ROW_TYPED,   -150, -4800, 12288},
        '{CAM_EXACT,      16'd10,    12'd200,   12'd150,   ROW_TYPED,   500, 32000, 40960},
        // z above 24 bits: point_z saturates while x keeps the full z
        '{CAM_EXACT,      16'd65535, 12'd4095,  12'd4095,  ROW_PREDICT, 0, 0, 0},
        '{CAM_EXACT,      16'd4096,  12'd4095,  12'd0,     ROW_PREDICT, 0, 0, 0}
    };

    // one lateral axis: |coord*16 - center| * z * recip in Q.44, rounded half away
    // from zero to Q.16, sign put back, then clipped to the signed 24-bit range
    function automatic logic [OUT_W-1:0] lateral_offset(logic [COORD_BITS-1:0] coord,
                                                        logic [CENTER_W-1:0] center,
                                                        logic [63:0] z,
                                                        logic [INV_W-1:0] recip);
        logic [127:0] pos;
        logic [127:0] ctr;
        logic [127:0] mag;
        logic [127:0] r;
        logic         neg;
        pos = 128'(coord) << 4;
        ctr = 128'(center);
        neg = pos < ctr;
        mag = neg ? ctr - pos : pos - ctr;
        r   = (mag * 128'(z) * 128'(recip) + (128'd1 << 27)) >> 28;
        if (!neg)
            return (r > 128'(POS_MAX)) ? OUT_W'(POS_MAX) : r[OUT_W-1:0];
        if (r > 128'(NEG_MAX))
            r = 128'(NEG_MAX);
        return OUT_W'(128'd0 - r);
    endfunction

    // the point a nonzero depth pixel should turn into under the current camera
    function automatic point_t backproject(pixel_t p);
        logic [63:0] z;
        logic [63:0] zxy;
        point_t      pt;
        z    = (64'(p.depth) * 64'(cam_inv_depth) + 64'd128) >> 8;
        zxy  = (z > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : z;
        pt.x = lateral_offset(p.col, cam_cx, zxy, cam_inv_fx);
        pt.y = lateral_offset(p.row, cam_cy, zxy, cam_inv_fy);
        pt.z = (z > 64'(24'hFFFFFF)) ? '1 : z[OUT_W-1:0];
        return pt;
    endfunction

    // register write as the block takes it: width kept, unknown indexes dropped
    function automatic void cam_write(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INV_DEPTH_SCALE: cam_inv_depth = data[INV_W-1:0];
            CFG_INV_FOCAL_X:     cam_inv_fx    = data[INV_W-1:0];
            CFG_INV_FOCAL_Y:     cam_inv_fy    = data[INV_W-1:0];
            CFG_CENTER_X:        cam_cx        = data[CENTER_W-1:0];
            CFG_CENTER_Y:        cam_cy        = data[CENTER_W-1:0];
            default:             ;
        endcase
    endfunction

    // book a point at the back of the owed list
    function automatic void owe_point(point_t p);
        pending_points.insert(pending_points.size(), p);
    endfunction

    function automatic logic [INV_W-1:0] corner_or_random(logic [INV_W-1:0] top);
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return top;
            default: return INV_W'($urandom) & top;
        endcase
    endfunction

    // camera for one random phase: mostly plausible sensors, some raw noise, some corners
    function automatic cam_cfg_t random_camera(int ph);
        cam_cfg_t c;
        case (ph % 4)
            2:
            begin
                c.inv_depth = INV_W'($urandom);
                c.inv_fx    = INV_W'($urandom);
                c.inv_fy    = INV_W'($urandom);
                c.cx        = CENTER_W'($urandom);
                c.cy        = CENTER_W'($urandom);
            end
            3:
            begin
                c.inv_depth = corner_or_random('1);
                c.inv_fx    = corner_or_random('1);
                c.inv_fy    = corner_or_random('1);
                c.cx        = CENTER_W'(corner_or_random(INV_W'(16'hFFFF)));
                c.cy        = CENTER_W'(corner_or_random(INV_W'(16'hFFFF)));
            end
            default:
            begin
                // 0.1 mm to 10 mm per unit, focal lengths of 100 to 3000 pixels
                c.inv_depth = INV_W'((1 << 24) / $urandom_range(100, 10000));
                c.inv_fx    = INV_W'((1 << 24) / $urandom_range(100, 3000));
                c.inv_fy    = INV_W'((1 << 24) / $urandom_range(100, 3000));
                c.cx        = CENTER_W'(16 * $urandom_range(100, 2000) + $urandom_range(0, 15));
                c.cy        = CENTER_W'(16 * $urandom_range(100, 2000) + $urandom_range(0, 15));
            end
        endcase
        return c;
    endfunction

    // pixel mix: some dropouts, some corners, some raw noise, some near the principal
    // point, the rest short to mid range depths anywhere in the image
    function automatic pixel_t random_pixel();
        pixel_t p;
        int     pick;
        int     c;
        pick  = $urandom_range(0, 19);
        p.col = COORD_BITS'($urandom);
        p.row = COORD_BITS'($urandom);
        case (pick)
            0, 1:    p.depth = '0;
            2:
            begin
                p.depth = $urandom_range(0, 1) ? '1 : DEPTH_BITS'(1);
                p.col   = $urandom_range(0, 1) ? '1 : '0;
                p.row   = $urandom_range(0, 1) ? '1 : '0;
            end
            3, 4, 5: p.depth = DEPTH_BITS'($urandom);
            6, 7:
            begin
                p.depth = DEPTH_BITS'($urandom_range(1, 8000));
                c = int'(cam_cx >> 4) + int'($urandom_range(0, 6)) - 3;
                p.col = COORD_BITS'((c < 0) ? 0 : (c > 4095) ? 4095 : c);
                c = int'(cam_cy >> 4) + int'($urandom_range(0, 6)) - 3;
                p.row = COORD_BITS'((c < 0) ? 0 : (c > 4095) ? 4095 : c);
            end
            default: p.depth = DEPTH_BITS'($urandom_range(1, 8000));
        endcase
        return p;
    endfunction

    // offer one item, maybe after an idle burst, and book what it should produce
    task automatic offer_pixel(input pixel_t px, input row_kind_t kind, input point_t typed);
        int gap;
        gap = 0;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.depth_value <= px.depth;
        pix_ch.pixel_col   <= px.col;
        pix_ch.pixel_row   <= px.row;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        // taken at this edge, so the camera in force right now applies
        n_pixels++;
        if (px.depth == '0)
            n_dropped++;
        else if (kind == ROW_TYPED)
            owe_point(typed);
        else
            owe_point(backproject(px));
    endtask

    // stop offering, let every owed point come out, then let dropped items clear too
    task automatic wait_for_points();
        int guard;
        guard = 0;
        pix_ch.valid <= 1'b0;
        while (pending_points.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cam_write(idx, data);
    endtask

    // full camera load; junk goes to the unused indexes and to the spare high bits
    // of the center registers, neither of which may stick
    task automatic load_camera(input cam_cfg_t c);
        write_reg(CFG_INV_DEPTH_SCALE, c.inv_depth);
        write_reg(CFG_INV_FOCAL_X, c.inv_fx);
        write_reg(CFG_INV_FOCAL_Y, c.inv_fy);
        for (int i = int'(CFG_CENTER_Y) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        write_reg(CFG_CENTER_X, {8'($urandom), c.cx});
        write_reg(CFG_CENTER_Y, {8'($urandom), c.cy});
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        n_cam_loads++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous cap on the whole run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d points still owed", pending_points.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // point side: ready in random bursts, one long hold-off on request, steady at the end
    initial
    begin
        pt_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                pt_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                pt_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                pt_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // checker: every point taken is matched against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_ch.valid && !pix_ch.ready)
                n_input_stalls++;
            if (pt_ch.valid && pt_ch.ready)
            begin
                n_points++;
                if (pending_points.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: point x=%0d y=%0d z=%0d with nothing owed", $realtime,
                                 pt_ch.point_x, pt_ch.point_y, pt_ch.point_z);
                end
                else
                begin
                    oldest_point = pending_points.pop_front();
                    if (pt_ch.point_x !== oldest_point.x || pt_ch.point_y !== oldest_point.y ||
                        pt_ch.point_z !== oldest_point.z)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("%0t: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                     $realtime, oldest_point.x, oldest_point.y, oldest_point.z,
                                     pt_ch.point_x, pt_ch.point_y, pt_ch.point_z);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int       cur_cam;
        int       nonzero;
        pixel_t   px;
        point_t   typed;
        dir_row_t r;

        rst_n              <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.depth_value <= '0;
        pix_ch.pixel_col   <= '0;
        pix_ch.pixel_row   <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.wdata       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; the first setting is the reset camera, never written
        cur_cam = CAM_DEFAULT;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            r = dir_rows[i];
            if (r.cam != cur_cam)
            begin
                wait_for_points();
                load_camera(dir_cams[r.cam]);
                cur_cam = r.cam;
            end
            px    = '{r.depth, r.col, r.row};
            typed = '{OUT_W'(r.want_x), OUT_W'(r.want_y), OUT_W'(r.want_z)};
            offer_pixel(px, r.kind, typed);
        end

        // random phases, each under its own camera, loaded once the block is empty
        typed = '0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_for_points();
            load_camera(random_camera(ph));
            // keep offering at full rate during the hold-off so the pipeline fills;
            // last phase runs with no idling on either side
            sender_idle_on = (ph != HOLD_PHASE) && (ph != RAND_PHASES - 1);
            sink_idle_on   = (ph != RAND_PHASES - 1);
            if (ph == HOLD_PHASE)
                hold_request = 1'b1;
            nonzero = 0;
            while (nonzero < ITEMS_PER_PHASE)
            begin
                px = random_pixel();
                offer_pixel(px, ROW_PREDICT, typed);
                if (px.depth != '0)
                    nonzero++;
            end
        end

        wait_for_points();
        if (pending_points.size() != 0)
            $display("%0d expected points never arrived", pending_points.size());
        $display("covered %0d pixel items (%0d dropouts), %0d camera loads, %0d points checked",
                 n_pixels, n_dropped, n_cam_loads, n_points);
        $display("input held off for %0d cycles in total, %0d mismatches",
                 n_input_stalls, n_mismatch);
        if (n_mismatch == 0 && pending_points.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> depth_pixel_backprojection.f
src/dpb_pkg.sv
src/dpb_if.sv
src/depth_pixel_backprojection.sv
test/tb_depth_pixel_backprojection.sv
